### hw/rtl/dpf_pkg.sv
package dpf_pkg;

  typedef enum logic [1:0] {
    FMT_NONE    = 2'd0,
    FMT_LONG    = 2'd1,
    FMT_COMPACT = 2'd2
  } fmt_e;

  typedef enum logic [2:0] {
    KIND_TAG    = 3'd0,
    KIND_ACCEPT = 3'd1,
    KIND_STALE  = 3'd2,
    KIND_SHORT  = 3'd3,
    KIND_MAGIC  = 3'd4
  } kind_e;

  localparam logic [1:0] CFG_MAGIC_LONG    = 2'd0;
  localparam logic [1:0] CFG_MAGIC_COMPACT = 2'd1;
  localparam logic [1:0] CFG_RESET_GAP     = 2'd2;

  localparam logic [15:0] RESET_GAP_DEFAULT = 16'd1000;

  localparam logic [4:0] HDR_LONG    = 5'd18;
  localparam logic [4:0] HDR_COMPACT = 5'd12;
  localparam logic [3:0] REC_LONG    = 4'd9;
  localparam logic [3:0] REC_COMPACT = 4'd5;

  localparam logic [11:0] POS_MAX = 12'd4095;

  localparam logic [63:0] ONE_NS_BITS = 64'h3E11_2E0B_E826_D695;
  localparam logic [63:0] F64_INF     = 64'h7FF0_0000_0000_0000;
  localparam logic [15:0] WRAP_HALF   = 16'h8000;

  typedef struct packed {
    kind_e              result_kind;
    logic [7:0]         cam_num;
    logic [15:0]        frame_number;
    logic [7:0]         tag_id;
    logic signed [15:0] angle_tenth_deg;
    logic [15:0]        range_tenth_in;
    logic [31:0]        capture_ms;
    logic               has_capture_time;
    logic [15:0]        lat_tenths;
    logic [31:0]        stale_drops;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic        rd_en;
    logic [7:0]  cam;
    logic        wr_en;
    logic [15:0] frame;
    logic [31:0] now;
  } cam_req_t;

  typedef struct packed {
    logic        accept;
    logic [31:0] drops_cur;
    logic [31:0] drops_upd;
  } cam_rsp_t;

  // Double seconds to milliseconds, truncated and saturated to 32 bits.
  function automatic logic [31:0] f64_to_ms(logic [63:0] b);
    logic [10:0] ex;
    logic [51:0] fr;
    logic [62:0] pm;
    logic [62:0] p;
    logic [11:0] s;
    logic [62:0] q;
    logic [31:0] r;
    ex = b[62:52];
    fr = b[51:0];
    pm = 63'({1'b1, fr});
    p  = (pm << 10) - (pm << 4) - (pm << 3);
    s  = 12'd1075 - {1'b0, ex};
    q  = '0;
    if (b[63]) begin
      r = '0;
    end else if (ex == 11'h7FF) begin
      r = (fr != '0) ? 32'd0 : 32'hFFFF_FFFF;
    end else if (ex == 11'd0) begin
      r = '0;
    end else if (ex >= 11'd1075) begin
      r = 32'hFFFF_FFFF;
    end else if (s >= 12'd63) begin
      r = '0;
    end else begin
      q = p >> s[5:0];
      r = (q[62:32] != '0) ? 32'hFFFF_FFFF : q[31:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/dpf_f32_fix.sv
module dpf_f32_fix
  import dpf_pkg::*;
#(
  parameter int unsigned K_MUL   = 10,
  parameter int unsigned POS_LIM = 32767,
  parameter int unsigned NEG_LIM = 32768
) (
  input  logic [31:0] f_i,
  output logic [15:0] fix_o
);

  logic        sign;
  logic [7:0]  ex;
  logic [22:0] fr;
  logic [7:0]  exn;
  logic [23:0] m;
  logic [39:0] p;
  logic [16:0] lim;
  logic [7:0]  sh;
  logic [55:0] shifted;
  logic [39:0] q;
  logic [40:0] qr;
  logic [39:0] rb_vec;
  logic [16:0] mag;

  assign sign = f_i[31];
  assign ex   = f_i[30:23];
  assign fr   = f_i[22:0];
  assign exn  = (ex == 8'd0) ? 8'd1 : ex;
  assign m    = (ex == 8'd0) ? {1'b0, fr} : {1'b1, fr};
  assign p    = 40'(m) * 40'(K_MUL);
  assign lim  = sign ? 17'(NEG_LIM) : 17'(POS_LIM);

  always_comb begin
    sh      = '0;
    shifted = '0;
    q       = '0;
    qr      = '0;
    rb_vec  = '0;
    if (ex == 8'hFF) begin
      mag = (fr != '0) ? 17'd0 : lim;
    end else if (p == '0) begin
      mag = '0;
    end else if (exn >= 8'd150) begin
      sh = exn - 8'd150;
      if (sh >= 8'd16) begin
        mag = lim;
      end else begin
        shifted = {16'd0, p} << sh[3:0];
        mag = (shifted > 56'(lim)) ? lim : shifted[16:0];
      end
    end else begin
      sh = 8'd150 - exn;
      if (sh >= 8'd41) begin
        mag = '0;
      end else begin
        q      = p >> sh[5:0];
        rb_vec = p >> (sh[5:0] - 6'd1);
        qr     = {1'b0, q} + 41'(rb_vec[0]);
        mag    = (qr > 41'(lim)) ? lim : qr[16:0];
      end
    end
  end

  assign fix_o = sign ? 16'(17'd0 - mag) : mag[15:0];

endmodule

### hw/rtl/dpf_cam_table.sv
module dpf_cam_table
  import dpf_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] gap_ms_i,
  input  cam_req_t    req_i,
  output cam_rsp_t    rsp_o
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic [15:0] frame;
    logic [31:0] stamp;
    logic [31:0] drops;
  } cam_ent_t;

  logic [SW-1:0] slot_lut [256];
  cam_ent_t      mem_q [SLOTS];
  cam_ent_t      rd_q;
  cam_ent_t      wr_ent;
  logic [SW-1:0] slot_q;
  logic [SLOTS-1:0] valid_q;
  logic          valid_cur;
  logic [15:0]   dfr;
  logic [31:0]   gap;
  logic          newer;
  logic          gap_over;

  for (genvar g = 0; g < 256; g++) begin : g_slot
    assign slot_lut[g] = SW'(g % SLOTS);
  end

  assign valid_cur = valid_q[slot_q];
  assign dfr       = req_i.frame - rd_q.frame;
  assign gap       = req_i.now - rd_q.stamp;
  assign newer     = (dfr != '0) && (dfr < WRAP_HALF);
  assign gap_over  = !gap[31] && (gap > {16'd0, gap_ms_i});

  always_comb begin
    rsp_o.accept    = !valid_cur || newer || gap_over;
    rsp_o.drops_cur = valid_cur ? rd_q.drops : 32'd0;
    if (rsp_o.accept || rsp_o.drops_cur == 32'hFFFF_FFFF) begin
      rsp_o.drops_upd = rsp_o.drops_cur;
    end else begin
      rsp_o.drops_upd = rsp_o.drops_cur + 32'd1;
    end
    wr_ent.frame = rsp_o.accept ? req_i.frame : rd_q.frame;
    wr_ent.stamp = rsp_o.accept ? req_i.now : rd_q.stamp;
    wr_ent.drops = rsp_o.drops_upd;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[slot_q] <= wr_ent;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[slot_lut[req_i.cam]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      valid_q <= '0;
    end else begin
      if (req_i.rd_en) begin
        slot_q <= slot_lut[req_i.cam];
      end
      if (req_i.wr_en) begin
        valid_q[slot_q] <= 1'b1;
      end
    end
  end

  a_rd_wr_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.rd_en |-> !req_i.wr_en)
    else $error("camera read and write in the same cycle");

  a_first_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.wr_en && !valid_cur) |-> rsp_o.accept)
    else $error("first frame of a camera rejected");

  a_valid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.wr_en |=> valid_q[slot_q])
    else $error("camera slot not marked valid after write");

endmodule

### hw/rtl/dpf_res_fifo.sv
module dpf_res_fifo
  import dpf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  result_t    res0_i,
  input  result_t    res1_i,
  output logic       room_o,
  output result_t    out_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  localparam int unsigned DEPTH = 4;

  result_t    mem_q [DEPTH];
  logic [1:0] wp_q;
  logic [1:0] rp_q;
  logic [2:0] cnt_q;
  logic [2:0] cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem_q[rp_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (cnt_q <= 3'(DEPTH - 2));
  assign cnt_d       = cnt_q + {1'b0, push_n_i} - {2'b0, pop};

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wp_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wp_q + 2'd1] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + push_n_i;
      rp_q  <= rp_q + {1'b0, pop};
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(DEPTH))
    else $error("result queue overflow");

  a_pair_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i == 2'd2) |-> (cnt_q <= 3'(DEPTH - 2)))
    else $error("two results pushed without room");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && push_n_i != 2'd0) |=> out_valid_o)
    else $error("pushed result not presented");

endmodule

### hw/rtl/detection_packet_parser_filter.sv
// Channel    | Direction | Fields
// s_axis     | in        | tdata: byte_value, recv_time_ms; tlast: last_byte
// m_axis     | out       | tdata: header/record values; tuser: result_kind; tlast: last_of_run
// cfg        | in        | write enable, register index, 16-bit data
//
// One byte is taken per clock while s_axis_tready is high; its results land in
// a four-entry result queue at the same edge, so with the queue empty the first
// one shows on m_axis in the cycle after the byte. A last byte that also closes
// a tag record yields two results; s_axis_tready falls while the queue holds
// more than two entries, so m_axis stalls reach the input before it fills. Reset
// clears all datagram state and the camera valid bits at once, with no clearing pass.
module detection_packet_parser_filter
  import dpf_pkg::*;
#(
  parameter int unsigned CAMERA_SLOTS = 256,
  parameter int unsigned MAX_TAGS     = 255
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // byte_value[7:0], recv_time_ms[39:8]
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cam_num[7:0], frame_number[23:8], tag_id[31:24], angle_tenth_deg[47:32],
  // range_tenth_in[63:48], capture_ms[95:64], has_capture_time[96],
  // lat_tenths[112:97], stale_drops[144:113], zero fill[151:145]
  output logic [151:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // result_kind[2:0]
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  logic [15:0] magic_long_q, magic_compact_q, gap_ms_q;

  logic [11:0] pos_q, pos_d, pos_u;
  logic [63:0] hshift_q, hshift_d, hshift_u;
  logic [7:0]  cam_q, cam_d, cam_u;
  logic [15:0] frame_q, frame_d, frame_u;
  logic [15:0] lat_q, lat_d, lat_u;
  logic        has_q, has_d, has_u;
  logic [31:0] cap_q, cap_d, cap_u;
  logic [63:0] rshift_q, rshift_d, rshift_u;
  logic [7:0]  rtag_q, rtag_d, rtag_u;
  logic [7:0]  tcnt_q, tcnt_d, tcnt_u;
  fmt_e        fmt_q, fmt_d, fmt_u;
  logic [3:0]  rec_w_q, rec_w_d, rec_w_u;
  logic [7:0]  rec_t_q, rec_t_d, rec_t_u;

  logic        acc;
  logic [7:0]  bv;
  logic [31:0] now;
  logic        lng;
  logic [4:0]  hdr;
  logic [3:0]  rsz;
  logic [63:0] hs_shift;
  logic [63:0] rs_shift;
  logic [15:0] magic;
  logic [15:0] lat_fix, ang_fix, rng_fix;
  logic        rec_v;
  logic [12:0] len, need;
  logic        len_ok;
  result_t     rec_res, stat_res, res0, res1;
  logic [1:0]  push_n;
  logic        room;
  result_t     out_res;
  cam_req_t    cam_req;
  cam_rsp_t    cam_rsp;

  assign acc      = s_axis_tvalid && s_axis_tready;
  assign bv       = s_axis_tdata[7:0];
  assign now      = s_axis_tdata[39:8];
  assign lng      = (fmt_q == FMT_LONG);
  assign hdr      = lng ? HDR_LONG : HDR_COMPACT;
  assign rsz      = lng ? REC_LONG : REC_COMPACT;
  assign hs_shift = {hshift_q[55:0], bv};
  assign rs_shift = (rec_w_q == 4'd0) ? 64'd0 : {rshift_q[55:0], bv};
  assign magic    = {hshift_q[7:0], bv};
  assign s_axis_tready = room;

  dpf_f32_fix #(.K_MUL(10000), .POS_LIM(65535), .NEG_LIM(0)) u_lat_fix (
    .f_i  (hs_shift[31:0]),
    .fix_o(lat_fix)
  );

  dpf_f32_fix #(.K_MUL(10), .POS_LIM(32767), .NEG_LIM(32768)) u_ang_fix (
    .f_i  (rs_shift[63:32]),
    .fix_o(ang_fix)
  );

  dpf_f32_fix #(.K_MUL(10), .POS_LIM(65535), .NEG_LIM(0)) u_rng_fix (
    .f_i  (rs_shift[31:0]),
    .fix_o(rng_fix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_long_q    <= '0;
      magic_compact_q <= '0;
      gap_ms_q        <= RESET_GAP_DEFAULT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAGIC_LONG:    magic_long_q    <= cfg_data_i;
        CFG_MAGIC_COMPACT: magic_compact_q <= cfg_data_i;
        CFG_RESET_GAP:     gap_ms_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Byte parser: header fields, then records.
  always_comb begin
    pos_u    = pos_q;
    hshift_u = hshift_q;
    cam_u    = cam_q;
    frame_u  = frame_q;
    lat_u    = lat_q;
    has_u    = has_q;
    cap_u    = cap_q;
    rshift_u = rshift_q;
    rtag_u   = rtag_q;
    tcnt_u   = tcnt_q;
    fmt_u    = fmt_q;
    rec_w_u  = rec_w_q;
    rec_t_u  = rec_t_q;
    rec_v    = 1'b0;
    if (acc) begin
      if (pos_q < 12'd2) begin
        hshift_u = hs_shift;
        if (pos_q == 12'd1) begin
          if (magic == magic_long_q) begin
            fmt_u = FMT_LONG;
          end else if (magic == magic_compact_q) begin
            fmt_u = FMT_COMPACT;
          end else begin
            fmt_u = FMT_NONE;
          end
        end
      end else if (fmt_q != FMT_NONE && pos_q < {7'd0, hdr}) begin
        hshift_u = hs_shift;
        if (pos_q == 12'd2) begin
          cam_u = bv;
        end else if (pos_q == 12'd4) begin
          frame_u = hs_shift[15:0];
        end else if (lng && pos_q == 12'd12) begin
          cap_u = f64_to_ms(hs_shift);
          has_u = !hs_shift[63] && (hs_shift > ONE_NS_BITS) && (hs_shift <= F64_INF);
        end else if (lng && pos_q == 12'd16) begin
          lat_u = lat_fix;
        end else if (!lng && pos_q == 12'd8) begin
          cap_u = hs_shift[31:0];
          has_u = (hs_shift[31:0] != '0);
        end else if (!lng && pos_q == 12'd10) begin
          lat_u = hs_shift[15:0];
        end else if (pos_q == {7'd0, hdr - 5'd1}) begin
          tcnt_u = bv;
        end
      end else if (fmt_q != FMT_NONE) begin
        if (rec_t_q < tcnt_q && {1'b0, rec_t_q} < 9'(MAX_TAGS)) begin
          if (rec_w_q == 4'd0) begin
            rtag_u = bv;
          end
          rshift_u = rs_shift;
          rec_v    = (rec_w_q == rsz - 4'd1);
        end
        // advance record counters; the record index holds once it reaches 255
        if (rec_w_q == rsz - 4'd1) begin
          rec_w_u = '0;
          if (rec_t_q != 8'hFF) begin
            rec_t_u = rec_t_q + 8'd1;
          end
        end else begin
          rec_w_u = rec_w_q + 4'd1;
        end
      end
      pos_u = (pos_q < POS_MAX) ? pos_q + 12'd1 : POS_MAX;
    end
  end

  // Status check and result assembly.
  always_comb begin
    len    = {1'b0, pos_q} + 13'd1;
    need   = lng ? {8'd0, hdr} + ({5'd0, tcnt_u} << 3) + {5'd0, tcnt_u}
                 : {8'd0, hdr} + ({5'd0, tcnt_u} << 2) + {5'd0, tcnt_u};
    len_ok = (len >= {8'd0, hdr}) && (len >= need);

    cam_req.rd_en = acc && (pos_q == 12'd2) && (fmt_q != FMT_NONE);
    cam_req.cam   = bv;
    cam_req.wr_en = acc && s_axis_tlast && (len >= 13'd2) && (fmt_u != FMT_NONE) && len_ok;
    cam_req.frame = frame_u;
    cam_req.now   = now;

    rec_res.result_kind      = KIND_TAG;
    rec_res.cam_num          = cam_u;
    rec_res.frame_number     = frame_u;
    rec_res.tag_id           = rtag_u;
    rec_res.angle_tenth_deg  = lng ? ang_fix : rs_shift[31:16];
    rec_res.range_tenth_in   = lng ? rng_fix : rs_shift[15:0];
    rec_res.capture_ms       = cap_u;
    rec_res.has_capture_time = has_u;
    rec_res.lat_tenths       = lat_u;
    rec_res.stale_drops      = cam_rsp.drops_cur;
    rec_res.last_of_run      = 1'b0;

    stat_res                  = rec_res;
    stat_res.tag_id           = '0;
    stat_res.angle_tenth_deg  = '0;
    stat_res.range_tenth_in   = '0;
    stat_res.stale_drops      = '0;
    stat_res.last_of_run      = 1'b1;
    if (len < 13'd2) begin
      stat_res.result_kind = KIND_SHORT;
    end else if (fmt_u == FMT_NONE) begin
      stat_res.result_kind = KIND_MAGIC;
    end else if (!len_ok) begin
      stat_res.result_kind = KIND_SHORT;
    end else begin
      stat_res.result_kind = cam_rsp.accept ? KIND_ACCEPT : KIND_STALE;
      stat_res.stale_drops = cam_rsp.drops_upd;
    end

    res0   = rec_v ? rec_res : stat_res;
    res1   = stat_res;
    push_n = 2'({1'b0, rec_v} + {1'b0, acc && s_axis_tlast});
  end

  // Drop all datagram state after its last byte.
  always_comb begin
    if (acc && s_axis_tlast) begin
      pos_d    = '0;
      hshift_d = '0;
      cam_d    = '0;
      frame_d  = '0;
      lat_d    = '0;
      has_d    = 1'b0;
      cap_d    = '0;
      rshift_d = '0;
      rtag_d   = '0;
      tcnt_d   = '0;
      fmt_d    = FMT_NONE;
      rec_w_d  = '0;
      rec_t_d  = '0;
    end else begin
      pos_d    = pos_u;
      hshift_d = hshift_u;
      cam_d    = cam_u;
      frame_d  = frame_u;
      lat_d    = lat_u;
      has_d    = has_u;
      cap_d    = cap_u;
      rshift_d = rshift_u;
      rtag_d   = rtag_u;
      tcnt_d   = tcnt_u;
      fmt_d    = fmt_u;
      rec_w_d  = rec_w_u;
      rec_t_d  = rec_t_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hshift_q <= '0;
      cam_q    <= '0;
      frame_q  <= '0;
      lat_q    <= '0;
      has_q    <= 1'b0;
      cap_q    <= '0;
      rshift_q <= '0;
      rtag_q   <= '0;
      tcnt_q   <= '0;
      fmt_q    <= FMT_NONE;
      rec_w_q  <= '0;
      rec_t_q  <= '0;
    end else begin
      pos_q    <= pos_d;
      hshift_q <= hshift_d;
      cam_q    <= cam_d;
      frame_q  <= frame_d;
      lat_q    <= lat_d;
      has_q    <= has_d;
      cap_q    <= cap_d;
      rshift_q <= rshift_d;
      rtag_q   <= rtag_d;
      tcnt_q   <= tcnt_d;
      fmt_q    <= fmt_d;
      rec_w_q  <= rec_w_d;
      rec_t_q  <= rec_t_d;
    end
  end

  dpf_cam_table #(.SLOTS(CAMERA_SLOTS)) u_cam_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .gap_ms_i(gap_ms_q),
    .req_i   (cam_req),
    .rsp_o   (cam_rsp)
  );

  dpf_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_n_i   (push_n),
    .res0_i     (res0),
    .res1_i     (res1),
    .room_o     (room),
    .out_o      (out_res),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, out_res.stale_drops, out_res.lat_tenths,
                         out_res.has_capture_time, out_res.capture_ms,
                         out_res.range_tenth_in, out_res.angle_tenth_deg,
                         out_res.tag_id, out_res.frame_number, out_res.cam_num};
  assign m_axis_tuser = out_res.result_kind;
  assign m_axis_tlast = out_res.last_of_run;

  a_rec_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_v |-> (fmt_q != FMT_NONE) && (pos_q >= {7'd0, hdr}))
    else $error("tag record emitted outside the record area");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && s_axis_tlast) |=> (pos_q == '0) && (fmt_q == FMT_NONE) && (tcnt_q == '0))
    else $error("datagram state not cleared after last byte");

  a_write_needs_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cam_req.wr_en |-> (pos_q >= {7'd0, hdr - 5'd1}))
    else $error("camera table written before header complete");

endmodule

### dv/tb_detection_packet_parser_filter.sv
module tb_detection_packet_parser_filter;
  import dpf_pkg::*;

  class parse_scoreboard;
    logic [15:0] magic_long, magic_compact, gap_ms;
    int unsigned pos;
    logic [63:0] hdr_shift, hdr_fields, rec_shift;
    logic [31:0] capture;
    logic [7:0]  rec_tag, tag_cnt;
    fmt_e        fmt;
    bit          cam_valid[256];
    logic [15:0] cam_frame[256];
    logic [31:0] cam_time[256];
    logic [31:0] cam_drops[256];
    result_t     expected_results[$];
    int          errors;

    function new();
      magic_long = '0;
      magic_compact = '0;
      gap_ms = RESET_GAP_DEFAULT;
      errors = 0;
      for (int i = 0; i < 256; i++) begin
        cam_valid[i] = 0;
        cam_drops[i] = '0;
        cam_frame[i] = '0;
        cam_time[i] = '0;
      end
      clear_dgram();
    endfunction

    function void clear_dgram();
      pos = 0;
      hdr_shift = '0;
      hdr_fields = '0;
      capture = '0;
      rec_shift = '0;
      rec_tag = '0;
      tag_cnt = '0;
      fmt = FMT_NONE;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_MAGIC_LONG:    magic_long = val;
        CFG_MAGIC_COMPACT: magic_compact = val;
        CFG_RESET_GAP:     gap_ms = val;
        default: ;
      endcase
    endfunction

    // m*k*2^e, rounded half up or truncated, clipped to lim
    function longint unsigned scaled(longint unsigned m, int e, longint unsigned k,
                                     bit rnd, longint unsigned lim);
      longint unsigned p, q;
      int s;
      p = m * k;
      if (p == 0) return 0;
      if (e >= 0) begin
        if (e >= 63) return lim;
        if (p > (lim >> e)) return lim;
        return p << e;
      end
      s = -e;
      if (s >= 64) return 0;
      q = p >> s;
      if (rnd && ((p >> (s - 1)) & 1)) q++;
      return (q > lim) ? lim : q;
    endfunction

    function logic [15:0] f32_fixed(logic [31:0] b, longint unsigned k,
                                    longint unsigned poslim, longint unsigned neglim);
      longint unsigned lim, mag;
      lim = b[31] ? neglim : poslim;
      if (b[30:23] == 8'hFF) begin
        if (b[22:0] != '0) return '0;
        mag = lim;
      end else if (b[30:23] == 8'h00) begin
        mag = scaled(64'(b[22:0]), -149, k, 1, lim);
      end else begin
        mag = scaled(64'({1'b1, b[22:0]}), int'(b[30:23]) - 150, k, 1, lim);
      end
      mag = b[31] ? (64'd0 - mag) : mag;
      return mag[15:0];
    endfunction

    function logic [31:0] seconds_to_ms(logic [63:0] b);
      longint unsigned r;
      if (b[63]) return '0;
      if (b[62:52] == 11'h7FF) return (b[51:0] != '0) ? 32'd0 : 32'hFFFF_FFFF;
      if (b[62:52] == '0) r = scaled(64'(b[51:0]), -1074, 1000, 0, 64'hFFFF_FFFF);
      else r = scaled(64'({1'b1, b[51:0]}), int'(b[62:52]) - 1075, 1000, 0, 64'hFFFF_FFFF);
      return r[31:0];
    endfunction

    function void push(kind_e kind, logic [7:0] tag, logic [15:0] ang, logic [15:0] rng,
                       logic [31:0] drops, logic last);
      result_t r;
      r.result_kind = kind;
      r.cam_num = hdr_fields[7:0];
      r.frame_number = hdr_fields[23:8];
      r.tag_id = tag;
      r.angle_tenth_deg = ang;
      r.range_tenth_in = rng;
      r.capture_ms = capture;
      r.has_capture_time = hdr_fields[40];
      r.lat_tenths = hdr_fields[39:24];
      r.stale_drops = drops;
      r.last_of_run = last;
      expected_results.push_back(r);
    endfunction

    function void predict_byte(logic [7:0] b, logic last, logic [31:0] now);
      bit lng, accept, newer, reopen;
      int unsigned hdr, rsz, off, t, w, len;
      logic [7:0] slot;
      logic [15:0] d, frame;
      logic [31:0] gap;
      lng = (fmt == FMT_LONG);
      hdr = lng ? 18 : 12;
      rsz = lng ? 9 : 5;
      slot = hdr_fields[7:0];
      if (pos < 2) begin
        hdr_shift = {hdr_shift[55:0], b};
        if (pos == 1)
          fmt = (hdr_shift[15:0] == magic_long) ? FMT_LONG :
                (hdr_shift[15:0] == magic_compact) ? FMT_COMPACT : FMT_NONE;
      end else if (fmt != FMT_NONE && pos < hdr) begin
        hdr_shift = {hdr_shift[55:0], b};
        if (pos == 2) hdr_fields[7:0] = b;
        else if (pos == 4) hdr_fields[23:8] = hdr_shift[15:0];
        else if (lng && pos == 12) begin
          capture = seconds_to_ms(hdr_shift);
          hdr_fields[40] = !hdr_shift[63] && hdr_shift > ONE_NS_BITS && hdr_shift <= F64_INF;
        end else if (lng && pos == 16)
          hdr_fields[39:24] = f32_fixed(hdr_shift[31:0], 10000, 65535, 0);
        else if (!lng && pos == 8) begin
          capture = hdr_shift[31:0];
          hdr_fields[40] = (capture != '0);
        end else if (!lng && pos == 10) hdr_fields[39:24] = hdr_shift[15:0];
        else if (pos == hdr - 1) tag_cnt = b;
      end else if (fmt != FMT_NONE) begin
        off = pos - hdr;
        t = off / rsz;
        w = off % rsz;
        if (t < tag_cnt && t < 255) begin
          if (w == 0) begin
            rec_tag = b;
            rec_shift = '0;
          end else rec_shift = {rec_shift[55:0], b};
          if (w == rsz - 1) begin
            if (lng)
              push(KIND_TAG, rec_tag, f32_fixed(rec_shift[63:32], 10, 32767, 32768),
                   f32_fixed(rec_shift[31:0], 10, 65535, 0), cam_drops[slot], 1'b0);
            else
              push(KIND_TAG, rec_tag, rec_shift[31:16], rec_shift[15:0],
                   cam_drops[slot], 1'b0);
          end
        end
      end
      if (!last) begin
        if (pos < 4095) pos++;
        return;
      end
      len = pos + 1;
      if (len < 2) push(KIND_SHORT, 0, 0, 0, 0, 1'b1);
      else if (fmt == FMT_NONE) push(KIND_MAGIC, 0, 0, 0, 0, 1'b1);
      else if (len < hdr || len < hdr + tag_cnt * rsz) push(KIND_SHORT, 0, 0, 0, 0, 1'b1);
      else begin
        frame = hdr_fields[23:8];
        accept = 1;
        if (cam_valid[slot]) begin
          d = frame - cam_frame[slot];
          gap = now - cam_time[slot];
          newer = d != 0 && d < WRAP_HALF;
          reopen = !gap[31] && gap > {16'd0, gap_ms};
          accept = newer || reopen;
        end
        if (accept) begin
          cam_valid[slot] = 1;
          cam_frame[slot] = frame;
          cam_time[slot] = now;
          push(KIND_ACCEPT, 0, 0, 0, cam_drops[slot], 1'b1);
        end else begin
          if (cam_drops[slot] != 32'hFFFF_FFFF) cam_drops[slot]++;
          push(KIND_STALE, 0, 0, 0, cam_drops[slot], 1'b1);
        end
      end
      clear_dgram();
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("ERROR %s: got %0h, expected %0h", what, got, want);
    endtask

    task check(result_t r);
      result_t e;
      if (expected_results.size() == 0) begin
        report("unexpected result, kind", r.result_kind, 0);
        return;
      end
      e = expected_results.pop_front();
      if (r.result_kind != e.result_kind) report("result_kind", r.result_kind, e.result_kind);
      if (r.cam_num != e.cam_num) report("cam_num", r.cam_num, e.cam_num);
      if (r.frame_number != e.frame_number)
        report("frame_number", r.frame_number, e.frame_number);
      if (r.tag_id != e.tag_id) report("tag_id", r.tag_id, e.tag_id);
      if (r.angle_tenth_deg != e.angle_tenth_deg)
        report("angle_tenth_deg", r.angle_tenth_deg, e.angle_tenth_deg);
      if (r.range_tenth_in != e.range_tenth_in)
        report("range_tenth_in", r.range_tenth_in, e.range_tenth_in);
      if (r.capture_ms != e.capture_ms) report("capture_ms", r.capture_ms, e.capture_ms);
      if (r.has_capture_time != e.has_capture_time)
        report("has_capture_time", r.has_capture_time, e.has_capture_time);
      if (r.lat_tenths != e.lat_tenths)
        report("lat_tenths", r.lat_tenths, e.lat_tenths);
      if (r.stale_drops != e.stale_drops) report("stale_drops", r.stale_drops, e.stale_drops);
      if (r.last_of_run != e.last_of_run) report("last_of_run", r.last_of_run, e.last_of_run);
    endtask
  endclass

  localparam int IDLE_LIMIT = 3000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [151:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we_i = 0;
  logic [1:0]   cfg_idx_i = '0;
  logic [15:0]  cfg_data_i = '0;

  parse_scoreboard sb = new();
  logic [7:0]  dgram[$];
  logic [15:0] gen_frame[256];
  logic [31:0] gen_now;
  int          burst_left = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;

  detection_packet_parser_filter DUT (.*);

  always #5 clk_i = ~clk_i;

  // checking and watchdog
  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      r.result_kind = kind_e'(m_axis_tuser);
      r.cam_num = m_axis_tdata[7:0];
      r.frame_number = m_axis_tdata[23:8];
      r.tag_id = m_axis_tdata[31:24];
      r.angle_tenth_deg = m_axis_tdata[47:32];
      r.range_tenth_in = m_axis_tdata[63:48];
      r.capture_ms = m_axis_tdata[95:64];
      r.has_capture_time = m_axis_tdata[96];
      r.lat_tenths = m_axis_tdata[112:97];
      r.stale_drops = m_axis_tdata[144:113];
      r.last_of_run = m_axis_tlast;
      sb.check(r);
      results_seen++;
    end
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || !rst_ni)
      idle_cycles = 0;
    else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("detection_packet_parser_filter: mismatch");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold once traffic is flowing
  initial begin
    int hold, mode;
    bit held;
    hold = 0;
    held = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= 150) begin
        held = 1;
        hold = 400;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (hold > 0) begin
        hold--;
        m_axis_tready = 0;
      end else if (!rst_ni) m_axis_tready = 0;
      else if (mode == 0) m_axis_tready = 1;
      else if (mode == 1) m_axis_tready = 1'($urandom_range(0, 1));
      else m_axis_tready = ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last, logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid = 0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid = 1;
    s_axis_tdata = {now, b};
    s_axis_tlast = last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.predict_byte(b, last, now);
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 0;
  endtask

  task automatic send_dgram(logic [31:0] now);
    foreach (dgram[i]) send_byte(dgram[i], i == dgram.size() - 1, now);
  endtask

  // change registers only once every expected result has drained
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    while (sb.expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i = 1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [31:0] rand_f32();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v[30:0] = '0;
      1: begin v[30:23] = 8'hFF; v[22] = 1; end
      2: v[30:0] = 31'h7F80_0000;
      3: v[30:23] = '0;
      7: ;
      default: v[30:23] = 8'($urandom_range(110, 142));
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rand_f64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 8))
      0: v[62:0] = '0;
      1: begin v[62:52] = 11'h7FF; v[51] = 1; end
      2: v = F64_INF;
      3: v = ONE_NS_BITS + 64'($urandom_range(0, 2)) - 64'd1;
      4: v[62:52] = '0;
      8: ;
      default: begin
        v[63] = $urandom_range(0, 5) == 0;
        v[62:52] = 11'($urandom_range(990, 1050));
      end
    endcase
    return v;
  endfunction

  function automatic void push_be(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) dgram.push_back(v[8 * i +: 8]);
  endfunction

  // well-formed datagram of the chosen format with random content
  function automatic void build_frame(bit lng, int tags);
    logic [7:0] cam;
    logic [15:0] m;
    int pick;
    pick = $urandom_range(0, 9);
    cam = (pick < 6) ? pick[7:0] : (pick < 8) ? 8'hFF : 8'($urandom);
    case ($urandom_range(0, 9))
      0: gen_frame[cam] = gen_frame[cam];
      1: gen_frame[cam] = gen_frame[cam] - 16'd1;
      2: gen_frame[cam] = gen_frame[cam] + WRAP_HALF;
      3: gen_frame[cam] = gen_frame[cam] + 16'h7FFF;
      4: gen_frame[cam] = 16'($urandom);
      default: gen_frame[cam] = gen_frame[cam] + 16'($urandom_range(1, 3));
    endcase
    m = lng ? sb.magic_long : sb.magic_compact;
    dgram.delete();
    push_be(64'(m), 2);
    dgram.push_back(cam);
    push_be(64'(gen_frame[cam]), 2);
    if (lng) begin
      push_be(rand_f64(), 8);
      push_be(64'(rand_f32()), 4);
    end else begin
      push_be(64'(($urandom_range(0, 3) == 0) ? 32'd0 : $urandom), 4);
      push_be(64'($urandom), 2);
    end
    dgram.push_back(8'(tags));
    for (int t = 0; t < tags; t++) begin
      dgram.push_back(8'($urandom));
      if (lng) begin
        push_be(64'(rand_f32()), 4);
        push_be(64'(rand_f32()), 4);
      end else push_be(64'($urandom), 4);
    end
  endfunction

  function automatic void advance_clock_ms();
    case ($urandom_range(0, 9))
      0: gen_now = $urandom;
      1: gen_now = gen_now - 32'($urandom_range(1, 5000));
      2: gen_now = gen_now + 32'($urandom_range(900, 70000));
      default: gen_now = gen_now + 32'($urandom_range(0, 400));
    endcase
  endfunction

  task automatic random_traffic(int byte_target);
    int sent, r, tags;
    logic [15:0] m;
    sent = 0;
    while (sent < byte_target) begin
      r = $urandom_range(0, 99);
      tags = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4);
      advance_clock_ms();
      if (r < 85 && sb.magic_long == sb.magic_compact) build_frame(1, tags);
      else if (r < 40) build_frame(1, tags);
      else if (r < 80) build_frame(0, tags);
      else if (r < 85) begin
        build_frame($urandom_range(0, 1), tags);
        dgram = dgram[0:$urandom_range(2, dgram.size() - 2)];
      end else if (r < 90) begin
        build_frame($urandom_range(0, 1), tags);
        repeat ($urandom_range(1, 12)) dgram.push_back(8'($urandom));
      end else if (r < 95) begin
        do m = 16'($urandom); while (m == sb.magic_long || m == sb.magic_compact);
        dgram.delete();
        push_be(64'(m), 2);
        repeat ($urandom_range(0, 20)) dgram.push_back(8'($urandom));
      end else begin
        dgram.delete();
        repeat ($urandom_range(1, 2)) dgram.push_back(8'($urandom));
      end
      send_dgram(gen_now);
      sent += dgram.size();
    end
  endtask

  initial begin
    logic [15:0] ml;
    for (int i = 0; i < 256; i++) gen_frame[i] = 16'($urandom);
    gen_now = $urandom;
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // registers at reset: both magics zero, so the long format wins
    dgram = '{8'h00};
    send_dgram(gen_now);
    dgram = '{8'h00, 8'h00};
    send_dgram(gen_now);
    dgram = '{8'h12, 8'h34, 8'h56};
    send_dgram(gen_now);
    build_frame(1, 1);
    send_dgram(gen_now);
    random_traffic(150);

    ml = 16'($urandom);
    write_reg(CFG_MAGIC_LONG, ml);
    write_reg(CFG_MAGIC_COMPACT, ~ml);
    random_traffic(300);

    write_reg(CFG_MAGIC_LONG, 16'hFFFF);
    write_reg(CFG_MAGIC_COMPACT, 16'h0000);
    write_reg(CFG_RESET_GAP, 16'd0);
    random_traffic(250);
    // full tag count, cut off after a few records
    build_frame(0, 255);
    dgram = dgram[0:40];
    send_dgram(gen_now);

    write_reg(CFG_RESET_GAP, 16'hFFFF);
    write_reg(CFG_MAGIC_COMPACT, 16'h8001);
    random_traffic(300);

    ml = 16'($urandom);
    write_reg(CFG_MAGIC_LONG, ml);
    write_reg(CFG_MAGIC_COMPACT, ml);
    write_reg(CFG_RESET_GAP, 16'($urandom_range(0, 2000)));
    random_traffic(100);
    write_reg(CFG_MAGIC_COMPACT, ~ml);
    random_traffic(300);

    while (sb.expected_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("detection_packet_parser_filter: match");
    else
      $display("detection_packet_parser_filter: mismatch");
    $finish;
  end

endmodule

### files.f
hw/rtl/dpf_pkg.sv
hw/rtl/dpf_f32_fix.sv
hw/rtl/dpf_cam_table.sv
hw/rtl/dpf_res_fifo.sv
hw/rtl/detection_packet_parser_filter.sv
dv/tb_detection_packet_parser_filter.sv
